>>> rtl/prf_pkg.sv
// Shared types and constants for the primitive root finder.
`timescale 1ns / 1ps
package prf_pkg;

  localparam int MOD_BITS     = 31;  // modulus / root field width
  localparam int TDATA_BITS   = 32;  // byte-padded stream data width
  localparam int SPECIAL_FOUR = 4;   // modulus with a fixed answer

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_FAIL,
    CMD_SET_ONE,
    CMD_SET_THREE,
    CMD_SET_G,
    CMD_FN_INIT,
    CMD_FP_INIT,
    CMD_DIV_TD,
    CMD_TD_DIVIDED,
    CMD_TD_NEXT,
    CMD_REC_N_D,
    CMD_REC_P_D,
    CMD_REC_N_M,
    CMD_REC_P_M,
    CMD_PHI_INIT,
    CMD_DIV_PHI,
    CMD_PHI_SUB,
    CMD_G_INIT,
    CMD_G_NEXT,
    CMD_GCD_INIT,
    CMD_DIV_GCD,
    CMD_GCD_STEP,
    CMD_IDX_INIT,
    CMD_IDX_NEXT,
    CMD_DIV_EXP,
    CMD_POW_INIT,
    CMD_MUL_ACC,
    CMD_ACC_LOAD,
    CMD_MUL_SQR,
    CMD_SQR_LOAD,
    CMD_EMIT
  } cmd_e;

  // datapath status toward the controller
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic d_gt_q;
    logic rem_zero;
    logic e_zero;
    logic m_gt1;
    logic n_zero;
    logic n_le2;
    logic n_four;
    logic has_root;
    logic p_ovf;
    logic g_ge_n;
    logic gb_zero;
    logic ga_gt1;
    logic idx_end;
    logic ex_zero;
    logic ex_odd;
    logic acc_one;
    logic out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SPECIAL,
    S_TD_START,
    S_TD_WAIT,
    S_TD_TAIL,
    S_N_CHECK,
    S_PHI_START,
    S_PHI_WAIT,
    S_FP_INIT,
    S_P_CHECK,
    S_G_CHECK,
    S_GCD_LOOP,
    S_GCD_WAIT,
    S_PR_CHECK,
    S_EXP_WAIT,
    S_POW_LOOP,
    S_MACC_WAIT,
    S_SQR_START,
    S_MSQR_WAIT,
    S_FINISH
  } state_e;

endpackage

>>> rtl/prf_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prf_div #(
  parameter int W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]   rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic [W:0]   shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[W-1:0];

endmodule

>>> rtl/prf_modmul.sv
// Modular multiplier, double-and-add over the multiplier bits, MSB first.
`timescale 1ns / 1ps
module prf_modmul #(
  parameter int W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,    // a < m
  input  logic [W-1:0] b_i,    // b < m
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  r_q, r_d, a_q, a_d, b_q, b_d, m_q, m_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W-1:0]  dbl, sum;

  always_comb begin
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    // 2r mod m and (2r + a) mod m without leaving W bits
    dbl = (r_q >= m_q - r_q) ? r_q - (m_q - r_q) : r_q + r_q;
    sum = (dbl >= m_q - a_q) ? dbl - (m_q - a_q) : dbl + a_q;
    if (start_i) begin
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = b_q[W-1] ? sum : dbl;
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

>>> rtl/prf_datapath.sv
// Datapath: working registers, factor store, divider, modular multiplier, output register.
`timescale 1ns / 1ps
module prf_datapath #(
  parameter int W   = 31,
  parameter int MPF = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  prf_pkg::cmd_e            cmd_i,
  input  logic [prf_pkg::MOD_BITS-1:0] modulus_i,
  input  logic                     out_ready_i,
  output prf_pkg::sts_t            sts_o,
  output logic                     out_valid_o,
  output logic [prf_pkg::MOD_BITS-1:0] out_root_o,
  output logic                     out_found_o
);
  import prf_pkg::*;

  localparam int EW = $clog2(W + 1);
  localparam int CW = $clog2(MPF + 1);
  localparam int IW = (MPF > 1) ? $clog2(MPF) : 1;

  logic [W-1:0]  n_q, m_q, d_q, phi_q, p0_q, plast_q, g_q, ga_q, gb_q;
  logic [W-1:0]  ex_q, acc_q, base_q, res_root_q;
  logic [EW-1:0] e_q, e0_q;
  logic [1:0]    ncnt_q;
  logic [CW-1:0] pcnt_q, idx_q;
  logic          povf_q, res_found_q;
  logic [W-1:0]  pf_q [MPF];
  logic          out_valid_q, out_found_q;
  logic [MOD_BITS-1:0] out_root_q;

  logic          div_start, div_busy, div_done, mul_start, mul_done;
  logic [W-1:0]  div_a, div_b, div_quo, div_rem, mul_a, mul_b, mul_prod;
  logic [W-1:0]  rec_p, pf_sel;
  logic [EW-1:0] rec_e;

  assign pf_sel = pf_q[idx_q[IW-1:0]];

  always_comb begin
    div_start = 1'b0;
    div_a     = m_q;
    div_b     = d_q;
    case (cmd_i)
      CMD_DIV_TD:  div_start = 1'b1;
      CMD_DIV_PHI: begin
        div_start = 1'b1;
        div_a     = phi_q;
        div_b     = plast_q;
      end
      CMD_DIV_GCD: begin
        div_start = 1'b1;
        div_a     = ga_q;
        div_b     = gb_q;
      end
      CMD_DIV_EXP: begin
        div_start = 1'b1;
        div_a     = phi_q;
        div_b     = pf_sel;
      end
      default: ;
    endcase
  end

  assign mul_start = (cmd_i == CMD_MUL_ACC) || (cmd_i == CMD_MUL_SQR);
  assign mul_a     = (cmd_i == CMD_MUL_ACC) ? acc_q : base_q;
  assign mul_b     = base_q;

  prf_div #(.W(W)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  prf_modmul #(.W(W)) u_mul (
    .clk_i,
    .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (n_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // tail record stores the leftover cofactor with exponent one
  assign rec_p = ((cmd_i == CMD_REC_N_M) || (cmd_i == CMD_REC_P_M)) ? m_q : d_q;
  assign rec_e = ((cmd_i == CMD_REC_N_M) || (cmd_i == CMD_REC_P_M)) ? EW'(1) : e_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: n_q <= W'(modulus_i);
      CMD_FN_INIT: begin
        m_q <= n_q;
        d_q <= W'(2);
        e_q <= '0;
      end
      CMD_FP_INIT: begin
        m_q <= phi_q;
        d_q <= W'(2);
        e_q <= '0;
      end
      CMD_TD_DIVIDED: begin
        m_q <= div_quo;
        e_q <= e_q + 1'b1;
      end
      CMD_TD_NEXT: d_q <= d_q + 1'b1;
      CMD_REC_N_D, CMD_REC_N_M: begin
        if (ncnt_q == 2'd0) begin
          p0_q <= rec_p;
          e0_q <= rec_e;
        end
        plast_q <= rec_p;
        d_q     <= d_q + 1'b1;
        e_q     <= '0;
      end
      CMD_REC_P_D, CMD_REC_P_M: begin
        if (pcnt_q < CW'(MPF)) pf_q[pcnt_q[IW-1:0]] <= rec_p;
        d_q <= d_q + 1'b1;
        e_q <= '0;
      end
      CMD_PHI_INIT: phi_q <= (ncnt_q == 2'd2) ? (n_q >> 1) : n_q;
      CMD_PHI_SUB:  phi_q <= phi_q - div_quo;
      CMD_G_INIT:   g_q <= W'(2);
      CMD_G_NEXT:   g_q <= g_q + 1'b1;
      CMD_GCD_INIT: begin
        ga_q <= n_q;
        gb_q <= g_q;
      end
      CMD_GCD_STEP: begin
        ga_q <= gb_q;
        gb_q <= div_rem;
      end
      CMD_POW_INIT: begin
        ex_q   <= div_quo;
        acc_q  <= W'(1);
        base_q <= g_q;
      end
      CMD_ACC_LOAD: acc_q <= mul_prod;
      CMD_SQR_LOAD: begin
        base_q <= mul_prod;
        ex_q   <= ex_q >> 1;
      end
      CMD_SET_FAIL:  res_root_q <= '0;
      CMD_SET_ONE:   res_root_q <= W'(1);
      CMD_SET_THREE: res_root_q <= W'(3);
      CMD_SET_G:     res_root_q <= g_q;
      default: ;
    endcase
  end

  // control-like counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q      <= '0;
      pcnt_q      <= '0;
      idx_q       <= '0;
      povf_q      <= 1'b0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_FN_INIT: ncnt_q <= '0;
        CMD_FP_INIT: begin
          pcnt_q <= '0;
          povf_q <= 1'b0;
        end
        CMD_REC_N_D, CMD_REC_N_M: if (ncnt_q != 2'd3) ncnt_q <= ncnt_q + 1'b1;
        CMD_REC_P_D, CMD_REC_P_M: begin
          if (pcnt_q < CW'(MPF)) pcnt_q <= pcnt_q + 1'b1;
          else povf_q <= 1'b1;
        end
        CMD_IDX_INIT: idx_q <= '0;
        CMD_IDX_NEXT: idx_q <= idx_q + 1'b1;
        CMD_SET_FAIL: res_found_q <= 1'b0;
        CMD_SET_ONE, CMD_SET_THREE, CMD_SET_G: res_found_q <= 1'b1;
        default: ;
      endcase
      if (cmd_i == CMD_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT) begin
      out_root_q  <= MOD_BITS'(res_root_q);
      out_found_q <= res_found_q;
    end
  end

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.mul_done = mul_done;
    sts_o.d_gt_q   = d_q > div_quo;
    sts_o.rem_zero = div_rem == '0;
    sts_o.e_zero   = e_q == '0;
    sts_o.m_gt1    = m_q > W'(1);
    sts_o.n_zero   = n_q == '0;
    sts_o.n_le2    = (n_q == W'(1)) || (n_q == W'(2));
    sts_o.n_four   = n_q == W'(SPECIAL_FOUR);
    sts_o.has_root = ((ncnt_q == 2'd1) && (p0_q > W'(2))) ||
                     ((ncnt_q == 2'd2) && (p0_q == W'(2)) && (e0_q == EW'(1)));
    sts_o.p_ovf    = povf_q;
    sts_o.g_ge_n   = g_q >= n_q;
    sts_o.gb_zero  = gb_q == '0;
    sts_o.ga_gt1   = ga_q > W'(1);
    sts_o.idx_end  = idx_q == pcnt_q;
    sts_o.ex_zero  = ex_q == '0;
    sts_o.ex_odd   = ex_q[0];
    sts_o.acc_one  = acc_q == W'(1);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_root_o  = out_root_q;
  assign out_found_o = out_found_q;

`ifndef NO_ASSERTIONS
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("output overwritten while held");
  a_found_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EMIT) |-> (res_found_q == (res_root_q != '0)))
    else $error("found flag disagrees with root");
`endif

endmodule

>>> rtl/prf_ctrl.sv
// Controller state machine sequencing the datapath commands.
`timescale 1ns / 1ps
module prf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prf_pkg::sts_t  sts_i,
  output prf_pkg::cmd_e  cmd_o
);
  import prf_pkg::*;

  state_e state_q, state_d;
  logic   fp_q, fp_d;  // 0: factoring n, 1: factoring phi

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fp_d    = fp_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o   = CMD_LOAD;
        state_d = S_SPECIAL;
      end
      S_SPECIAL: begin
        state_d = S_FINISH;
        if (sts_i.n_zero) cmd_o = CMD_SET_FAIL;
        else if (sts_i.n_le2) cmd_o = CMD_SET_ONE;
        else if (sts_i.n_four) cmd_o = CMD_SET_THREE;
        else begin
          cmd_o   = CMD_FN_INIT;
          fp_d    = 1'b0;
          state_d = S_TD_START;
        end
      end
      S_TD_START: begin
        cmd_o   = CMD_DIV_TD;
        state_d = S_TD_WAIT;
      end
      S_TD_WAIT: if (sts_i.div_done) begin
        state_d = S_TD_START;
        if (sts_i.e_zero && sts_i.d_gt_q) state_d = S_TD_TAIL;
        else if (sts_i.rem_zero) cmd_o = CMD_TD_DIVIDED;
        else if (sts_i.e_zero) cmd_o = CMD_TD_NEXT;
        else cmd_o = fp_q ? CMD_REC_P_D : CMD_REC_N_D;
      end
      S_TD_TAIL: begin
        if (sts_i.m_gt1) cmd_o = fp_q ? CMD_REC_P_M : CMD_REC_N_M;
        state_d = fp_q ? S_P_CHECK : S_N_CHECK;
      end
      S_N_CHECK: begin
        if (!sts_i.has_root) begin
          cmd_o   = CMD_SET_FAIL;
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_PHI_INIT;
          state_d = S_PHI_START;
        end
      end
      S_PHI_START: begin
        cmd_o   = CMD_DIV_PHI;
        state_d = S_PHI_WAIT;
      end
      S_PHI_WAIT: if (sts_i.div_done) begin
        cmd_o   = CMD_PHI_SUB;
        fp_d    = 1'b1;
        state_d = S_FP_INIT;
      end
      S_FP_INIT: begin
        cmd_o   = CMD_FP_INIT;
        state_d = S_TD_START;
      end
      S_P_CHECK: begin
        if (sts_i.p_ovf) begin
          cmd_o   = CMD_SET_FAIL;
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_G_INIT;
          state_d = S_G_CHECK;
        end
      end
      S_G_CHECK: begin
        if (sts_i.g_ge_n) begin
          cmd_o   = CMD_SET_FAIL;
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_GCD_INIT;
          state_d = S_GCD_LOOP;
        end
      end
      S_GCD_LOOP: begin
        if (!sts_i.gb_zero) begin
          cmd_o   = CMD_DIV_GCD;
          state_d = S_GCD_WAIT;
        end else if (sts_i.ga_gt1) begin
          cmd_o   = CMD_G_NEXT;
          state_d = S_G_CHECK;
        end else begin
          cmd_o   = CMD_IDX_INIT;
          state_d = S_PR_CHECK;
        end
      end
      S_GCD_WAIT: if (sts_i.div_done) begin
        cmd_o   = CMD_GCD_STEP;
        state_d = S_GCD_LOOP;
      end
      S_PR_CHECK: begin
        if (sts_i.idx_end) begin
          cmd_o   = CMD_SET_G;
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_DIV_EXP;
          state_d = S_EXP_WAIT;
        end
      end
      S_EXP_WAIT: if (sts_i.div_done) begin
        cmd_o   = CMD_POW_INIT;
        state_d = S_POW_LOOP;
      end
      S_POW_LOOP: begin
        if (sts_i.ex_zero) begin
          if (sts_i.acc_one) begin
            cmd_o   = CMD_G_NEXT;
            state_d = S_G_CHECK;
          end else begin
            cmd_o   = CMD_IDX_NEXT;
            state_d = S_PR_CHECK;
          end
        end else if (sts_i.ex_odd) begin
          cmd_o   = CMD_MUL_ACC;
          state_d = S_MACC_WAIT;
        end else begin
          cmd_o   = CMD_MUL_SQR;
          state_d = S_MSQR_WAIT;
        end
      end
      S_MACC_WAIT: if (sts_i.mul_done) begin
        cmd_o   = CMD_ACC_LOAD;
        state_d = S_SQR_START;
      end
      S_SQR_START: begin
        cmd_o   = CMD_MUL_SQR;
        state_d = S_MSQR_WAIT;
      end
      S_MSQR_WAIT: if (sts_i.mul_done) begin
        cmd_o   = CMD_SQR_LOAD;
        state_d = S_POW_LOOP;
      end
      S_FINISH: if (sts_i.out_free) begin
        cmd_o   = CMD_EMIT;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

`ifndef NO_ASSERTIONS
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_LOAD) |-> (state_q == S_IDLE)) else $error("load outside idle");
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_EMIT) |=> (state_q == S_IDLE)) else $error("emit did not return to idle");
  a_phi_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_CHECK) |-> fp_q) else $error("phi check while factoring n");
`endif

endmodule

>>> rtl/primitive_root_finder_core.sv
// Top level of the smallest-primitive-root finder.
`timescale 1ns / 1ps
// Usage:
//   Input stream (s_axis_*): one transaction carries a modulus n in tdata[30:0].
//   Output stream (m_axis_*): one transaction per input, tdata[30:0] holds the
//   smallest primitive root modulo n (0 if none), tuser holds the found flag.
//   Only the low VALUE_BITS bits of the modulus are used.
// Operation:
//   n = 0, 1, 2, 4 are answered directly. Otherwise n is factored by trial
//   division (a divide per trial, trial divisors up to sqrt(n)), phi(n) is formed
//   and factored the same way, then candidates are tested by Euclid gcd and
//   square-and-multiply with the serial modular multiplier. The shared serial
//   divider dominates the run time.
// Throughput: one modulus at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the next modulus is accepted
// while an earlier result waits for the receiver.
// Reset: rst_ni (asynchronous, active low) returns to idle, drops tvalid.
// Stall: a held result keeps the block in its finish step until taken.
module primitive_root_finder_core #(
  parameter int VALUE_BITS        = 31,
  parameter int MAX_PRIME_FACTORS = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [prf_pkg::TDATA_BITS-1:0] s_axis_tdata_i,   // [30:0] modulus
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [prf_pkg::TDATA_BITS-1:0] m_axis_tdata_o,   // [30:0] root
  output logic                           m_axis_tuser_o    // [0] found
);
  import prf_pkg::*;

  cmd_e                cmd;
  sts_t                sts;
  logic [MOD_BITS-1:0] root;

  prf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prf_datapath #(
    .W   (VALUE_BITS),
    .MPF (MAX_PRIME_FACTORS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .modulus_i   (s_axis_tdata_i[MOD_BITS-1:0]),
    .out_ready_i (m_axis_tready_i),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_root_o  (root),
    .out_found_o (m_axis_tuser_o)
  );

  // root padded to a whole number of bytes
  assign m_axis_tdata_o = TDATA_BITS'(root);

endmodule

>>> tb/tb.sv
// Testbench for primitive_root_finder_core: directed and random moduli, self-checking.
`timescale 1ns / 1ps
module tb;
  import prf_pkg::*;

  localparam int MAX_PF    = 9;
  localparam int N_RANDOM  = 77;
  localparam int TAIL_CYC  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [TDATA_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  typedef struct packed {
    logic [MOD_BITS-1:0] root;
    logic                found;
  } answer_t;

  logic [MOD_BITS-1:0] moduli_q[$];
  answer_t             answers_q[$];
  int n_total = 0, n_sent = 0, n_accepted = 0, n_checked = 0;
  int n_found = 0, n_errors = 0;

  primitive_root_finder_core dut (.*);

  always #10 clk_i = ~clk_i;

  // ---- predictor ----
  function automatic void factor_out(input longint unsigned v,
                                     output longint unsigned pr[MAX_PF],
                                     output int ex[MAX_PF], output int cnt,
                                     output bit ovf);
    longint unsigned d;
    int e;
    cnt = 0;
    ovf = 1'b0;
    for (int i = 0; i < MAX_PF; i++) begin
      pr[i] = 0;
      ex[i] = 0;
    end
    d = 2;
    while (d <= v / d) begin
      if (v % d == 0) begin
        e = 0;
        while (v % d == 0) begin
          v = v / d;
          e++;
        end
        if (cnt < MAX_PF) begin
          pr[cnt] = d;
          ex[cnt] = e;
          cnt++;
        end else ovf = 1'b1;
      end
      d++;
    end
    if (v > 1) begin
      if (cnt < MAX_PF) begin
        pr[cnt] = v;
        ex[cnt] = 1;
        cnt++;
      end else ovf = 1'b1;
    end
  endfunction

  function automatic longint unsigned power_mod(input longint unsigned b,
                                                input longint unsigned e,
                                                input longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned gcd_of(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic answer_t predict_root(input logic [MOD_BITS-1:0] modulus);
    longint unsigned n, phi;
    longint unsigned np[MAX_PF], pp[MAX_PF];
    int ne[MAX_PF], pe[MAX_PF];
    int ncnt, pcnt;
    bit novf, povf, good;
    answer_t a;
    a = '0;
    n = modulus;
    if (n == 0) return a;
    if (n <= 2) return '{root: 1, found: 1'b1};
    if (n == SPECIAL_FOUR) return '{root: 3, found: 1'b1};
    factor_out(n, np, ne, ncnt, novf);
    if (novf) return a;
    // root exists only for odd prime powers and twice odd prime powers
    if (!((ncnt == 1 && np[0] > 2) || (ncnt == 2 && np[0] == 2 && ne[0] == 1)))
      return a;
    phi = 1;
    for (int i = 0; i < ncnt; i++) begin
      phi = phi * (np[i] - 1);
      for (int k = 1; k < ne[i]; k++) phi = phi * np[i];
    end
    factor_out(phi, pp, pe, pcnt, povf);
    if (povf) return a;
    for (longint unsigned g = 2; g < n; g++) begin
      if (gcd_of(g, n) > 1) continue;
      good = 1'b1;
      for (int i = 0; i < pcnt; i++)
        if (power_mod(g, phi / pp[i], n) == 1) begin
          good = 1'b0;
          break;
        end
      if (good) begin
        a.root = g[MOD_BITS-1:0];
        a.found = 1'b1;
        return a;
      end
    end
    return a;
  endfunction

  function automatic bit is_prime(input int v);
    if (v < 2) return 1'b0;
    for (int d = 2; d * d <= v; d++) if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // idling phase follows progress through the stimulus
  function automatic int phase_now();
    return (n_total == 0) ? 0 : (n_sent * 4) / (n_total + 1);
  endfunction

  // ---- driver: changes inputs at the falling edge ----
  always @(negedge clk_i) begin
    int ph;
    ph = phase_now();
    if (rst_ni) begin
      if (!(s_axis_tvalid_i && n_sent > n_accepted)) begin
        if (moduli_q.size() > 0 &&
            !((ph == 1 && $urandom_range(99) < 48) || (ph == 3 && $urandom_range(99) < 38)))
        begin
          s_axis_tdata_i <= {1'b0, moduli_q.pop_front()};
          s_axis_tvalid_i <= 1'b1;
          n_sent <= n_sent + 1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= !((ph == 2 && $urandom_range(99) < 48) ||
                           (ph == 3 && $urandom_range(99) < 38));
    end
  end

  // ---- monitor: samples at the rising edge ----
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        answers_q.push_back(predict_root(s_axis_tdata_i[MOD_BITS-1:0]));
        n_accepted <= n_accepted + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (answers_q.size() == 0) begin
          $error("result transaction with no modulus pending: root %0d found %0b",
                 m_axis_tdata_o[MOD_BITS-1:0], m_axis_tuser_o);
          n_errors++;
        end else begin
          want = answers_q.pop_front();
          if (m_axis_tdata_o[MOD_BITS-1:0] !== want.root) begin
            $error("root: expected %0d, got %0d", want.root, m_axis_tdata_o[MOD_BITS-1:0]);
            n_errors++;
          end
          if (m_axis_tuser_o !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, m_axis_tuser_o);
            n_errors++;
          end
          if (want.found) n_found++;
        end
        n_checked++;
      end
    end
  end

  // ---- stimulus ----
  initial begin
    int p, k, kind;
    longint unsigned v, f;
    int small_primes[$];
    logic [MOD_BITS-1:0] directed[] = '{
      0, 1, 2, 3, 4, 5, 7, 8, 9, 12, 18, 25, 27, 49, 50, 97, 98, 4093, 65537,
      31'h4000_0000,   // top bit alone, power of two: no root
      31'h7FFF_FFFE,   // all bits but the lowest, smooth composite
      31'd1162261467,  // 3^19, large odd prime power
      31'd774840978    // 2 * 3^18
    };
    for (int i = 3; i < 600; i++) if (is_prime(i)) small_primes.push_back(i);
    foreach (directed[i]) moduli_q.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // odd prime power, sometimes doubled: the path that reaches the root search
        p = small_primes[$urandom_range(small_primes.size() - 1)];
        v = p;
        k = $urandom_range(3);
        while (k > 0 && v * p < 16384) begin
          v = v * p;
          k--;
        end
        if ($urandom_range(1)) v = v * 2;
        moduli_q.push_back(v[MOD_BITS-1:0]);
      end else if (kind < 85) begin
        moduli_q.push_back(MOD_BITS'($urandom_range(4095)));
      end else begin
        // large smooth value: sets the high bits while factoring stays quick
        v = 1;
        while (1) begin
          f = (longint'(small_primes[$urandom_range(8)]) > 23) ? 2 :
              small_primes[$urandom_range(8)];
          if ($urandom_range(3) == 0) f = 2;
          if (v * f >= 64'h8000_0000 || (v > 64'h100_0000 && $urandom_range(5) == 0)) break;
          v = v * f;
        end
        moduli_q.push_back(v[MOD_BITS-1:0]);
      end
    end
    n_total = moduli_q.size();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (n_checked >= n_total);
    repeat (TAIL_CYC) @(posedge clk_i);
    $display("Checked %0d results for %0d moduli (%0d with a root).",
             n_checked, n_total, n_found);
    $display("Covered special moduli, prime powers, doubled prime powers and smooth values.");
    if (n_errors == 0 && answers_q.size() == 0 && n_checked == n_total) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
